// ----- rtl/ahc_pkg.sv -----
// Shared types and constants for the 3x3 affine Hill cipher block.
// No dependencies.
package ahc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_W   = 45;
  localparam int unsigned LTR_W   = 5;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned OCHAR_W = 7;
  localparam int unsigned SUM_W   = 12;
  localparam int unsigned QUO_W   = 7;

  localparam logic [44:0] MATRIX_RESET = 45'd1099512676353;
  localparam logic [14:0] OFFSET_RESET = 15'd0;

  localparam logic [7:0] ASCII_UP_A = 8'h41;
  localparam logic [7:0] ASCII_UP_Z = 8'h5a;
  localparam logic [7:0] ASCII_LO_A = 8'h61;
  localparam logic [7:0] ASCII_LO_Z = 8'h7a;

  typedef enum logic [1:0] {
    REG_KEY     = 2'd0,
    REG_OFFSET  = 2'd1,
    REG_INVERSE = 2'd2,
    REG_MODE    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [44:0] key;
    logic [14:0] offset;
    logic [44:0] inverse;
    logic        decrypt;
  } cfg_t;

  // One closed group, already offset-corrected when decrypting.
  typedef struct packed {
    logic [2:0][LTR_W-1:0] x;
    logic                  bad;
    logic                  last;
  } group_t;

endpackage

// ----- rtl/ahc_front.sv -----
// Front end: classifies characters, gathers groups of three, pads on last.
// Depends on ahc_pkg.
module ahc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ahc_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           char_in_i,
  input  logic                 last_in_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output ahc_pkg::group_t      group_o
);
  import ahc_pkg::*;

  logic [1:0]       count_q, count_d;
  logic             bad_q, bad_d;
  logic [LTR_W-1:0] held0_q, held1_q;
  logic             is_upper, is_lower, bad_now, complete, accept;
  logic [7:0]       diff;
  logic [LTR_W-1:0] val;
  logic [2:0][LTR_W-1:0] v;

  function automatic logic [LTR_W-1:0] sub_mod(input logic [LTR_W-1:0] a,
                                               input logic [LTR_W-1:0] b);
    logic [6:0] t;
    t = 7'(a) + 7'd52 - 7'(b);
    if (t >= 7'd52) begin
      t = t - 7'd52;
    end else if (t >= 7'd26) begin
      t = t - 7'd26;
    end
    return t[LTR_W-1:0];
  endfunction

  assign is_upper = (char_in_i >= ASCII_UP_A) && (char_in_i <= ASCII_UP_Z);
  assign is_lower = (char_in_i >= ASCII_LO_A) && (char_in_i <= ASCII_LO_Z);
  assign bad_now  = !(is_upper || is_lower);
  assign diff     = is_upper ? (char_in_i - ASCII_UP_A) : (char_in_i - ASCII_LO_A);
  assign val      = bad_now ? '0 : diff[LTR_W-1:0];

  assign complete   = last_in_i || (count_q == 2'd2);
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && complete;

  always_comb begin
    v = '0;
    unique case (count_q)
      2'd0: begin
        v[0] = val;
      end
      2'd1: begin
        v[0] = held0_q;
        v[1] = val;
      end
      default: begin
        v[0] = held0_q;
        v[1] = held1_q;
        v[2] = val;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      group_o.x[k] = cfg_i.decrypt ? sub_mod(v[k], cfg_i.offset[LTR_W*k +: LTR_W]) : v[k];
    end
    group_o.bad  = bad_q || bad_now;
    group_o.last = last_in_i;
  end

  always_comb begin
    count_d = count_q;
    bad_d   = bad_q;
    if (accept) begin
      if (complete) begin
        count_d = 2'd0;
        bad_d   = 1'b0;
      end else begin
        count_d = count_q + 2'd1;
        bad_d   = bad_q || bad_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      bad_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      bad_q   <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !complete) begin
      if (count_q == 2'd0) begin
        held0_q <= val;
      end else begin
        held1_q <= val;
      end
    end
  end

endmodule

// ----- rtl/ahc_queue.sv -----
// Small FIFO of closed groups between front and back end.
// Depends on ahc_pkg.
module ahc_queue #(
  parameter int unsigned Depth = ahc_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ahc_pkg::group_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ahc_pkg::group_t data_o
);
  import ahc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  group_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/ahc_back.sv -----
// Back end: one matrix row per cycle while the output is not stalled, three-stage pipe with mod-26 reduction.
// Depends on ahc_pkg.
module ahc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ahc_pkg::cfg_t   cfg_i,
  input  logic            q_valid_i,
  input  ahc_pkg::group_t q_data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [6:0]      char_out_o,
  output logic            bad_char_o,
  output logic            last_out_o
);
  import ahc_pkg::*;

  localparam logic [SUM_W-1:0] RECIP = SUM_W'(2521);

  logic [44:0]      mat;
  logic [LTR_W-1:0] e0, e1, e2, off;
  logic [1:0]       row_q;
  logic             adv, take;
  logic [SUM_W-1:0] sum;
  logic [2*SUM_W-1:0] prod;
  logic [SUM_W-1:0] rem;

  logic             s1_vld_q, s1_bad_q, s1_last_q;
  logic [SUM_W-1:0] s1_sum_q;
  logic             s2_vld_q, s2_bad_q, s2_last_q;
  logic [SUM_W-1:0] s2_sum_q;
  logic [QUO_W-1:0] s2_quo_q;
  logic             out_vld_q, out_bad_q, out_last_q;
  logic [OCHAR_W-1:0] out_char_q;

  assign adv   = !out_vld_q || out_ready_i;
  assign take  = adv && q_valid_i;
  assign pop_o = take && (row_q == 2'd2);
  assign mat   = cfg_i.decrypt ? cfg_i.inverse : cfg_i.key;

  always_comb begin
    unique case (row_q)
      2'd0: begin
        e0 = mat[0 +: LTR_W];
        e1 = mat[5 +: LTR_W];
        e2 = mat[10 +: LTR_W];
        off = cfg_i.offset[0 +: LTR_W];
      end
      2'd1: begin
        e0 = mat[15 +: LTR_W];
        e1 = mat[20 +: LTR_W];
        e2 = mat[25 +: LTR_W];
        off = cfg_i.offset[5 +: LTR_W];
      end
      default: begin
        e0 = mat[30 +: LTR_W];
        e1 = mat[35 +: LTR_W];
        e2 = mat[40 +: LTR_W];
        off = cfg_i.offset[10 +: LTR_W];
      end
    endcase
  end

  assign sum = SUM_W'(e0 * q_data_i.x[0]) + SUM_W'(e1 * q_data_i.x[1])
             + SUM_W'(e2 * q_data_i.x[2]) + (cfg_i.decrypt ? '0 : SUM_W'(off));

  assign prod = s1_sum_q * RECIP;
  assign rem  = s2_sum_q - SUM_W'(s2_quo_q * 5'd26);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= 2'd0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        row_q <= (row_q == 2'd2) ? 2'd0 : row_q + 2'd1;
      end
      if (adv) begin
        s1_vld_q  <= q_valid_i;
        s2_vld_q  <= s1_vld_q;
        out_vld_q <= s2_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sum_q   <= sum;
      s1_bad_q   <= q_data_i.bad;
      s1_last_q  <= q_data_i.last && (row_q == 2'd2);
      s2_sum_q   <= s1_sum_q;
      s2_quo_q   <= prod[2*SUM_W-2-:QUO_W];
      s2_bad_q   <= s1_bad_q;
      s2_last_q  <= s1_last_q;
      out_char_q <= ASCII_LO_A[OCHAR_W-1:0] + OCHAR_W'(rem[LTR_W-1:0]);
      out_bad_q  <= s2_bad_q;
      out_last_q <= s2_last_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign char_out_o  = out_char_q;
  assign bad_char_o  = out_bad_q;
  assign last_out_o  = out_last_q;

endmodule

// ----- rtl/affine_hill_cipher_3x3.sv -----
// Top level: configuration registers, front end, group queue, back end.
// A closed group passes through the queue, then the back end's s1, s2 and output registers;
// its three results leave in row order. With full groups and no output stall, sustained rate
// is one character in and one result out per cycle, set by the back end's one-row-per-cycle pipe.
// Reset clears the group state, the queue and the pipe; key and inverse reset
// to identity, offset and mode to zero. Depends on ahc_pkg and the ahc_* modules.
module affine_hill_cipher_3x3 #(
  parameter int unsigned QueueDepth = ahc_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [44:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  char_out_o,
  output logic        bad_char_o,
  output logic        last_out_o
);
  import ahc_pkg::*;

  cfg_t   cfg_q;
  group_t push_data, head_data;
  logic   push, pop, q_full, q_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key     <= MATRIX_RESET;
      cfg_q.offset  <= OFFSET_RESET;
      cfg_q.inverse <= MATRIX_RESET;
      cfg_q.decrypt <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_KEY:     cfg_q.key     <= cfg_data_i;
        REG_OFFSET:  cfg_q.offset  <= cfg_data_i[14:0];
        REG_INVERSE: cfg_q.inverse <= cfg_data_i;
        REG_MODE:    cfg_q.decrypt <= cfg_data_i[0];
        default:     cfg_q.decrypt <= cfg_q.decrypt;
      endcase
    end
  end

  ahc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .char_in_i  (char_in_i),
    .last_in_i  (last_in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .group_o    (push_data)
  );

  ahc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_data)
  );

  ahc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (head_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_out_o  (char_out_o),
    .bad_char_o  (bad_char_o),
    .last_out_o  (last_out_o)
  );

endmodule

// ----- verif/ahc_tb_pkg.sv -----
// Scoreboard for the 3x3 affine Hill cipher testbench: a cycle-free predictor of
// the cipher plus the queue of output letters it still owes.
// Depends on ahc_pkg for register indexes, reset values and ASCII constants.
`timescale 1ns / 1ps

package ahc_tb_pkg;
  import ahc_pkg::*;

  typedef struct packed {
    logic [6:0] letter;
    logic       bad;
    logic       last;
  } cipher_out_t;

  class cipher_scoreboard;
    logic [44:0] key_m;
    logic [44:0] inv_m;
    logic [14:0] offset_v;
    logic        decrypt;
    logic [4:0]  held [2];
    int unsigned held_n;
    logic        group_bad;
    cipher_out_t pending_letters [$];
    int unsigned n_chars;
    int unsigned n_letters;
    int unsigned n_mismatch;

    function new();
      key_m      = MATRIX_RESET;
      inv_m      = MATRIX_RESET;
      offset_v   = OFFSET_RESET;
      decrypt    = 1'b0;
      held[0]    = '0;
      held[1]    = '0;
      held_n     = 0;
      group_bad  = 1'b0;
      n_chars    = 0;
      n_letters  = 0;
      n_mismatch = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [44:0] data);
      case (idx)
        REG_KEY:     key_m    = data;
        REG_OFFSET:  offset_v = data[14:0];
        REG_INVERSE: inv_m    = data;
        REG_MODE:    decrypt  = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned field5(logic [44:0] word, int unsigned k);
      return int'(word[5*k +: 5]);
    endfunction

    // Runs one closed group through the matrix and queues its three letters.
    function void cipher_group(int unsigned v[3], logic is_last);
      logic [44:0] mat;
      int unsigned x[3];
      int unsigned acc;
      cipher_out_t res;
      mat = decrypt ? inv_m : key_m;
      for (int col = 0; col < 3; col++) begin
        if (decrypt) begin
          x[col] = (v[col] + 52 - field5({30'd0, offset_v}, col)) % 26;
        end else begin
          x[col] = v[col];
        end
      end
      for (int row = 0; row < 3; row++) begin
        acc = 0;
        for (int col = 0; col < 3; col++) begin
          acc += field5(mat, row * 3 + col) * x[col];
        end
        if (!decrypt) begin
          acc += field5({30'd0, offset_v}, row);
        end
        res.letter = 7'(int'(ASCII_LO_A) + acc % 26);
        res.bad    = group_bad;
        res.last   = is_last && (row == 2);
        pending_letters.push_back(res);
      end
    endfunction

    function void note_input(logic [7:0] c, logic is_last);
      logic [7:0] ch;
      int unsigned val;
      int unsigned v[3];
      ch  = c;
      val = 0;
      n_chars++;
      if (ch >= ASCII_UP_A && ch <= ASCII_UP_Z) begin
        ch = ch + 8'd32;
      end
      if (ch >= ASCII_LO_A && ch <= ASCII_LO_Z) begin
        val = ch - ASCII_LO_A;
      end else begin
        group_bad = 1'b1;
      end
      if (held_n < 2 && !is_last) begin
        held[held_n] = val[4:0];
        held_n++;
        return;
      end
      v = '{0, 0, 0};
      for (int k = 0; k < held_n; k++) begin
        v[k] = held[k];
      end
      v[held_n] = val;
      cipher_group(v, is_last);
      held[0]   = '0;
      held[1]   = '0;
      held_n    = 0;
      group_bad = 1'b0;
    endfunction

    function void check_result(logic [6:0] ch, logic bad, logic is_last);
      cipher_out_t exp_r;
      n_letters++;
      if (pending_letters.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("ERROR: unexpected output %h bad %b last %b", ch, bad, is_last);
        end
        return;
      end
      exp_r = pending_letters.pop_front();
      if (exp_r.letter !== ch || exp_r.bad !== bad || exp_r.last !== is_last) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("ERROR: output %0d: expected %h bad %b last %b, got %h bad %b last %b",
                   n_letters, exp_r.letter, exp_r.bad, exp_r.last, ch, bad, is_last);
        end
      end
    endfunction

    function int unsigned pending();
      return pending_letters.size();
    endfunction
  endclass

endpackage

// ----- verif/tb_top.sv -----
// Top-level testbench for affine_hill_cipher_3x3: directed and random character
// streams across several key settings, with random source gaps and sink stalls.
// Depends on ahc_pkg, ahc_tb_pkg and the cipher RTL.
`timescale 1ns / 1ps

module tb_top;
  import ahc_pkg::*;
  import ahc_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [44:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  char_in;
  logic        last_in;
  logic        out_valid;
  logic        out_ready;
  logic [6:0]  char_out;
  logic        bad_char;
  logic        last_out;

  cipher_scoreboard sb;
  int unsigned snd_pct = 0;
  int unsigned rcv_pct = 0;
  bit          stall_request = 1'b0;

  affine_hill_cipher_3x3 dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .char_in_i   (char_in),
    .last_in_i   (last_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .char_out_o  (char_out),
    .bad_char_o  (bad_char),
    .last_out_o  (last_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sample every transaction and register write at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        sb.write_reg(reg_idx_e'(cfg_idx), cfg_data);
      end
      if (in_valid && in_ready) begin
        sb.note_input(char_in, last_in);
      end
      if (out_valid && out_ready) begin
        sb.check_result(char_out, bad_char, last_out);
      end
    end
  end

  // Sink: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        hold_left     = 60;
        stall_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("ERROR: timeout");
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [44:0] rand45();
    logic [63:0] t;
    t = {$urandom(), $urandom()};
    return t[44:0];
  endfunction

  function automatic logic [44:0] rand_matrix(bit in_range);
    logic [44:0] m;
    m = '0;
    for (int k = 0; k < 9; k++) begin
      m[5*k +: 5] = in_range ? 5'($urandom_range(25)) : 5'($urandom_range(31));
    end
    return m;
  endfunction

  function automatic logic [7:0] random_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) begin
      return 8'(int'(ASCII_LO_A) + $urandom_range(25));
    end else if (r < 88) begin
      return 8'(int'(ASCII_UP_A) + $urandom_range(25));
    end
    return 8'($urandom_range(255));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_char(logic [7:0] c, logic l);
    while ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    last_in  <= l;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic program_regs(logic [44:0] key_w, logic [44:0] off_w,
                              logic [44:0] inv_w, logic [44:0] mode_w);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_KEY;
    cfg_data <= key_w;
    @(negedge clk);
    cfg_idx  <= REG_OFFSET;
    cfg_data <= off_w;
    @(negedge clk);
    cfg_idx  <= REG_INVERSE;
    cfg_data <= inv_w;
    @(negedge clk);
    cfg_idx  <= REG_MODE;
    cfg_data <= mode_w;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
  endtask

  initial begin
    logic [44:0] key_w;
    logic [44:0] off_w;
    logic [44:0] inv_w;
    logic [44:0] mode_w;
    logic [44:0] r45;
    logic [44:0] rm;
    logic        l;
    sb = new();
    rst_n    <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= REG_KEY;
    cfg_data <= '0;
    in_valid <= 1'b0;
    char_in  <= '0;
    last_in  <= 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset keys: identity, no offset, encrypt.
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    send_char("c", 1'b0);
    send_char("Z", 1'b0);
    send_char("z", 1'b0);
    send_char("A", 1'b0);
    send_char(8'h40, 1'b0);
    send_char(8'h5b, 1'b0);
    send_char(8'h60, 1'b0);
    send_char(8'h7b, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_char("m", 1'b1);
    send_char("Q", 1'b0);
    send_char(8'h80, 1'b1);
    send_char("x", 1'b0);
    send_char("y", 1'b0);
    send_char("K", 1'b1);
    in_valid <= 1'b0;
    drain();

    for (int ph = 1; ph <= 7; ph++) begin
      case (ph)
        1: begin
          key_w  = rand_matrix(1'b1);
          rm     = rand_matrix(1'b1);
          off_w  = {30'd0, rm[14:0]};
          inv_w  = rand_matrix(1'b1);
          r45    = rand45();
          mode_w = {r45[44:1], 1'b0};
        end
        2: begin
          key_w  = rand_matrix(1'b1);
          r45    = rand45();
          rm     = rand_matrix(1'b1);
          off_w  = {r45[44:15], rm[14:0]};
          inv_w  = rand_matrix(1'b1);
          mode_w = 45'd1;
        end
        3: begin
          key_w  = '1;
          off_w  = '1;
          inv_w  = '1;
          mode_w = '1;
        end
        4: begin
          key_w  = '0;
          off_w  = '0;
          inv_w  = '0;
          mode_w = '0;
        end
        5: begin
          key_w  = rand45();
          off_w  = rand45();
          inv_w  = rand45();
          r45    = rand45();
          mode_w = {r45[44:1], 1'b0};
        end
        6: begin
          key_w  = rand_matrix(1'b0);
          off_w  = rand45();
          inv_w  = rand_matrix(1'b0);
          r45    = rand45();
          mode_w = {r45[44:1], 1'b1};
        end
        default: begin
          key_w  = '1;
          off_w  = '1;
          inv_w  = rand_matrix(1'b1);
          mode_w = 45'd0;
        end
      endcase
      program_regs(key_w, off_w, inv_w, mode_w);
      snd_pct = (ph % 4 == 1) ? 52 : (ph % 4 == 3) ? 11 : 0;
      rcv_pct = (ph % 4 == 2) ? 52 : (ph % 4 == 3) ? 11 : 0;
      for (int i = 0; i < 70; i++) begin
        if (ph == 4 && i == 10) begin
          stall_request = 1'b1;
        end
        l = (i == 69) || ($urandom_range(9) == 0);
        send_char(random_char(), l);
      end
      in_valid <= 1'b0;
      drain();
    end

    $display("Covered %0d characters over 8 key settings (encrypt, decrypt, all-zero and",
             sb.n_chars);
    $display("all-one keys), with gaps, stalls and a long sink hold; %0d letters checked.",
             sb.n_letters);
    if (sb.pending() != 0) begin
      $display("ERROR: %0d expected letters never arrived", sb.pending());
    end
    if (sb.n_mismatch == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
